// ----- rtl/mcrtb_pkg.sv -----
`default_nettype none

package mcrtb_pkg;

    // Bank size and per-tick notice limit
    localparam int NUM_TIMERS  = 8;
    localparam int MAX_RESULTS = 8;

    localparam int TIMER_AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int NCNT_W   = $clog2(MAX_RESULTS + 1);

    // Field widths
    localparam int CMD_W   = 3;
    localparam int IDX_W   = 8;
    localparam int VAL_W   = 32;
    localparam int KIND_W  = 2;
    localparam int S_DATA_W = 80;
    localparam int M_DATA_W = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK   = 3'd0,
        CMD_CONFIG = 3'd1,
        CMD_START  = 3'd2,
        CMD_STOP   = 3'd3,
        CMD_QUERY  = 3'd4
    } t_cmd;

    typedef enum logic [KIND_W-1:0] {
        KIND_DONE       = 2'd0,
        KIND_REJECT     = 2'd1,
        KIND_NOTICE     = 2'd2,
        KIND_TICK_QUIET = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMD,
        S_WALK,
        S_END
    } t_state;

    // One timer as stored in the memory
    typedef struct packed {
        logic [VAL_W-1:0] count;
        logic [VAL_W-1:0] reload;
        logic             flag;
        logic             notify;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // One result beat
    typedef struct packed {
        t_kind            kind;
        logic [IDX_W-1:0] which;
        logic             tout;
        logic             last;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/mcrtb_ram.sv -----
`default_nettype none

module mcrtb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                          i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/multi_channel_reload_timer_bank_unit.sv -----
`default_nettype none

// Bank of NUM_TIMERS down-counting timers with auto-reload.
// Slave stream: tuser carries the command, tdata the timer index, count,
// reload and notify bit. Master stream: tuser carries the result kind,
// tdata the timer number and the query answer, tlast marks the final beat
// of the results of one command.
// Configure, start, stop and query read the addressed timer from the state
// memory, modify it and write it back in the command state, where the
// single result is loaded into the output register once it is free.
// A tick walks the memory one timer per cycle, unless a stalled receiver
// holds it, through its single read port. Notices are delayed by one
// expiring timer so that tlast can be set on the final one.
// A new command is taken only when the previous one has finished; the
// output register lets the next command enter while a result is waiting.
// When the receiver stalls, the walk holds on the next timer that needs to
// send a notice, and single commands hold until the output register frees.
// Reset clears every timer at once through per-entry valid bits; an entry
// never written reads as zero. No clearing pass is needed.

module multi_channel_reload_timer_bank_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // slave stream
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    // tdata: timer_index[7:0], count_value[39:8], reload_value[71:40],
    //        notify_enable[72], zero pad[79:73]
    input  wire logic [mcrtb_pkg::S_DATA_W-1:0] i_s_tdata,
    // tuser: cmd[2:0]
    input  wire logic [mcrtb_pkg::CMD_W-1:0]    i_s_tuser,
    // master stream
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    // tdata: which_timer[7:0], timed_out[8], zero pad[15:9]
    output logic      [mcrtb_pkg::M_DATA_W-1:0] o_m_tdata,
    // tuser: kind[1:0]
    output logic      [mcrtb_pkg::KIND_W-1:0]   o_m_tuser,
    output logic                               o_m_tlast
);

    import mcrtb_pkg::*;

    t_state                r_state, n_state;
    logic [TIMER_AW-1:0]   r_ptr, n_ptr;
    t_cmd                  r_cmd;
    logic [IDX_W-1:0]      r_idx;
    logic [VAL_W-1:0]      r_cval;
    logic [VAL_W-1:0]      r_rval;
    logic                  r_nen;
    logic                  r_pend_vld, n_pend_vld;
    logic [TIMER_AW-1:0]   r_pend_idx, n_pend_idx;
    logic [NCNT_W-1:0]     r_ncnt, n_ncnt;
    logic [NUM_TIMERS-1:0] r_vld;
    logic                  r_out_vld;
    t_result               r_out, n_out;

    logic                  s_accept;
    logic                  out_free;
    logic                  push;
    logic                  walk_done;
    logic                  cmd_done;

    logic                  ram_we;
    logic [TIMER_AW-1:0]   ram_waddr;
    logic [TIMER_AW-1:0]   ram_raddr;
    t_entry                ram_wdata;
    logic [ENTRY_W-1:0]    ram_rdata;

    t_entry                cur;
    logic                  active;
    logic [VAL_W-1:0]      dec;
    logic                  expire;
    logic                  notice;
    logic                  last_entry;
    logic                  reject;

    assign s_accept   = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_vld || i_m_tready;
    assign last_entry = (r_ptr == TIMER_AW'(NUM_TIMERS - 1));
    assign reject     = (r_cmd > CMD_QUERY) || (r_idx >= IDX_W'(NUM_TIMERS));

    // Entry under work; an unwritten entry reads as zero
    assign cur    = r_vld[r_ptr] ? t_entry'(ram_rdata) : '0;
    assign active = (cur.count != '0);
    assign dec    = cur.count - VAL_W'(1);
    assign expire = active && (dec == '0);
    assign notice = expire && cur.notify && (r_ncnt < NCNT_W'(MAX_RESULTS));

    mcrtb_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_TIMERS)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_state = (t_cmd'(i_s_tuser) == CMD_TICK) ? S_WALK : S_CMD;
                end
            end
            S_CMD: begin
                if (cmd_done) begin
                    n_state = S_IDLE;
                end
            end
            S_WALK: begin
                if (walk_done) begin
                    n_state = S_END;
                end
            end
            S_END: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath controls, memory write-back and result beats
    always_comb begin
        o_s_tready = 1'b0;
        n_ptr      = r_ptr;
        n_pend_vld = r_pend_vld;
        n_pend_idx = r_pend_idx;
        n_ncnt     = r_ncnt;
        n_out      = r_out;
        push       = 1'b0;
        walk_done  = 1'b0;
        cmd_done   = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = r_ptr;
        ram_wdata  = cur;
        ram_raddr  = r_ptr;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (t_cmd'(i_s_tuser) == CMD_TICK) begin
                    n_ptr = '0;
                end else begin
                    n_ptr = i_s_tdata[TIMER_AW-1:0];
                end
                n_pend_vld = 1'b0;
                n_ncnt     = '0;
                ram_raddr  = n_ptr;
            end
            S_CMD: begin
                if (out_free) begin
                    cmd_done  = 1'b1;
                    push      = 1'b1;
                    n_out     = '{kind: KIND_DONE, which: r_idx, tout: 1'b0, last: 1'b1};
                    if (reject) begin
                        n_out.kind = KIND_REJECT;
                    end else begin
                        ram_we = 1'b1;
                        case (r_cmd)
                            CMD_CONFIG: begin
                                ram_wdata = '{count: r_cval, reload: r_rval,
                                              flag: 1'b0, notify: r_nen};
                            end
                            CMD_START: begin
                                ram_wdata.count = r_cval;
                                ram_wdata.flag  = 1'b0;
                            end
                            CMD_STOP: begin
                                ram_wdata.count = '0;
                            end
                            CMD_QUERY: begin
                                n_out.tout     = cur.flag;
                                ram_wdata.flag = 1'b0;
                            end
                            default: ram_we = 1'b0;
                        endcase
                    end
                end
            end
            S_WALK: begin
                // hold the walk only when a held notice must leave first
                if (!(notice && r_pend_vld) || out_free) begin
                    ram_we = 1'b1;
                    if (expire) begin
                        ram_wdata.count = cur.reload;
                        ram_wdata.flag  = 1'b1;
                    end else if (active) begin
                        ram_wdata.count = dec;
                    end
                    if (notice) begin
                        if (r_pend_vld) begin
                            push  = 1'b1;
                            n_out = '{kind: KIND_NOTICE, which: IDX_W'(r_pend_idx),
                                      tout: 1'b0, last: 1'b0};
                        end
                        n_pend_vld = 1'b1;
                        n_pend_idx = r_ptr;
                        n_ncnt     = r_ncnt + NCNT_W'(1);
                    end
                    if (last_entry) begin
                        walk_done = 1'b1;
                    end else begin
                        n_ptr = r_ptr + TIMER_AW'(1);
                    end
                    ram_raddr = r_ptr + TIMER_AW'(1);
                end
            end
            S_END: begin
                if (out_free) begin
                    push = 1'b1;
                    if (r_pend_vld) begin
                        n_out = '{kind: KIND_NOTICE, which: IDX_W'(r_pend_idx),
                                  tout: 1'b0, last: 1'b1};
                    end else begin
                        n_out = '{kind: KIND_TICK_QUIET, which: '0,
                                  tout: 1'b0, last: 1'b1};
                    end
                    n_pend_vld = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_pend_vld <= 1'b0;
            r_vld      <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_pend_vld <= n_pend_vld;
            if (ram_we) begin
                r_vld[ram_waddr] <= 1'b1;
            end
            if (push) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_ptr      <= n_ptr;
        r_pend_idx <= n_pend_idx;
        r_ncnt     <= n_ncnt;
        if (push) begin
            r_out <= n_out;
        end
        if (s_accept) begin
            r_cmd  <= t_cmd'(i_s_tuser);
            r_idx  <= i_s_tdata[7:0];
            r_cval <= i_s_tdata[39:8];
            r_rval <= i_s_tdata[71:40];
            r_nen  <= i_s_tdata[72];
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {{(M_DATA_W - IDX_W - 1){1'b0}}, r_out.tout, r_out.which};
    assign o_m_tuser  = r_out.kind;
    assign o_m_tlast  = r_out.last;

endmodule

`default_nettype wire
